// File: rtl/core/tsr_pkg.sv
`default_nettype none
package tsr_pkg;
  localparam int unsigned OpW = 4;
  localparam int unsigned SpdW = 18;
  localparam int unsigned RateW = 20;
  localparam int unsigned MsW = 7;
  localparam int unsigned ClkW = 24;
  localparam int unsigned CntW = 16;
  localparam int unsigned StW = 3;
  localparam int unsigned PhW = 2;
  localparam int unsigned AddrW = 5;

  localparam logic [OpW-1:0] OP_TICK = 4'd0;
  localparam logic [OpW-1:0] OP_STEP = 4'd1;
  localparam logic [OpW-1:0] OP_ZERO = 4'd2;
  localparam logic [OpW-1:0] OP_HAND = 4'd3;
  localparam logic [OpW-1:0] OP_MOTOR = 4'd4;
  localparam logic [OpW-1:0] OP_HOMING = 4'd5;
  localparam logic [OpW-1:0] OP_CONT = 4'd6;
  localparam logic [OpW-1:0] OP_SOFT = 4'd7;
  localparam logic [OpW-1:0] OP_HARD = 4'd8;

  localparam logic [StW-1:0] ST_INIT = 3'd0;
  localparam logic [StW-1:0] ST_STOPPED = 3'd1;
  localparam logic [StW-1:0] ST_HOME = 3'd2;
  localparam logic [StW-1:0] ST_DIST = 3'd3;
  localparam logic [StW-1:0] ST_CONT = 3'd4;
  localparam logic [StW-1:0] ST_HOMING = 3'd5;

  localparam logic [PhW-1:0] PH_STOP = 2'd0;
  localparam logic [PhW-1:0] PH_ACCEL = 2'd1;
  localparam logic [PhW-1:0] PH_CONST = 2'd2;
  localparam logic [PhW-1:0] PH_DECEL = 2'd3;

  localparam logic [AddrW-1:0] REG_START = 5'd0;
  localparam logic [AddrW-1:0] REG_MAX = 5'd4;
  localparam logic [AddrW-1:0] REG_ACCEL = 5'd8;
  localparam logic [AddrW-1:0] REG_DECEL = 5'd12;
  localparam logic [AddrW-1:0] REG_UPD = 5'd16;
  localparam logic [AddrW-1:0] REG_TCLK = 5'd20;
  localparam logic [AddrW-1:0] REG_MOVE = 5'd24;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           dir;
    logic           zero_clear;
  } in_t;

  typedef struct packed {
    logic [StW-1:0]  run_state;
    logic [PhW-1:0]  ramp_phase;
    logic [SpdW-1:0] speed;
    logic [ClkW-1:0] step_period;
    logic            direction;
    logic            drive_enable;
    logic [CntW-1:0] steps_done;
  } out_t;
endpackage
`default_nettype wire

// File: rtl/core/tsr_if.sv
`default_nettype none
interface tsr_in_if;
  logic valid;
  logic ready;
  tsr_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsr_out_if;
  logic valid;
  logic ready;
  tsr_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/trapezoid_stepper_ramp_top.sv
`default_nettype none
// Work per item: a run start takes one 38-bit period divide; a ramp update on a tick can
// take a 38-bit brake estimate divide, a 38-bit period divide, both one bit a cycle, and
// two reciprocal multiplies for the divides by 1000.
// Throughput: one item at a time; the next item is taken the cycle after the result is.
// The result register frees the input side once taken.
// Reset: rst_ni asynchronous active low, registers to their documented reset values.
module trapezoid_stepper_ramp_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tsr_in_if.sink          in_if,
  tsr_out_if.source       out_if,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import tsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EST_A, S_EST_B, S_EST_DIV, S_MARG_DIV, S_CHK,
    S_CHG_A, S_CHG_DIV, S_APPLY, S_PER_DIV, S_OUT
  } state_e;

  localparam int unsigned DW = 38;
  localparam int unsigned MulW = 29;
  localparam int unsigned MsShift = 38;
  // ceil(2^38 / 1000), exact floor division by 1000 for the 29-bit multiplier operands
  localparam logic [MulW-1:0] MsRecip = 29'd274877907;

  state_e state_q;
  logic [SpdW-1:0] start_q, maxs_q, speed_q;
  logic [RateW-1:0] acc_q, dec_q;
  logic [MsW-1:0] upd_q, ms_q, el_q;
  logic [ClkW-1:0] tclk_q, period_q;
  logic [CntW-1:0] move_q, cnt_q;
  logic [StW-1:0] rs_q;
  logic [PhW-1:0] ph_q;
  logic dir_q, en_q, outv_q;
  logic [DW-1:0] num_q, den_q, quo_q, rem_q, est_q, chg_q;
  logic [5:0] bit_q;
  logic [MulW-1:0] mul_a, mul_b;
  logic [2*MulW-1:0] prod;
  logic [DW-1:0] ms_quo;
  logic [DW-1:0] rem_sh;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_comb begin
    case (paddr)
      REG_START: prdata = {14'd0, start_q};
      REG_MAX:   prdata = {14'd0, maxs_q};
      REG_ACCEL: prdata = {12'd0, acc_q};
      REG_DECEL: prdata = {12'd0, dec_q};
      REG_UPD:   prdata = {25'd0, upd_q};
      REG_TCLK:  prdata = {8'd0, tclk_q};
      REG_MOVE:  prdata = {16'd0, move_q};
      default:   prdata = 32'd0;
    endcase
  end

  assign in_if.ready = (state_q == S_IDLE) && !outv_q;
  assign out_if.valid = outv_q;
  assign out_if.data = '{run_state: rs_q, ramp_phase: ph_q, speed: speed_q,
                         step_period: period_q, direction: dir_q, drive_enable: en_q,
                         steps_done: cnt_q};

  assign rem_sh = {rem_q[DW-2:0], num_q[DW-1]};

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_EST_A: begin
        mul_a = MulW'(speed_q); mul_b = MulW'(speed_q);
      end
      S_EST_B: begin
        mul_a = MulW'(start_q); mul_b = MulW'(start_q);
      end
      S_CHG_A: begin
        mul_a = (ph_q == PH_ACCEL) ? MulW'(acc_q) : MulW'(dec_q);
        mul_b = MulW'(el_q);
      end
      S_MARG_DIV, S_CHG_DIV: begin
        mul_a = num_q[MulW-1:0]; mul_b = MsRecip;
      end
      default: begin
        mul_a = MulW'(speed_q); mul_b = MulW'(upd_q);
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign ms_quo = DW'(prod[2*MulW-1:MsShift]);

  function automatic logic running(input logic [StW-1:0] s);
    return s == ST_DIST || s == ST_CONT || s == ST_HOMING;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 18'd400; maxs_q <= 18'd3200; acc_q <= 20'd4000; dec_q <= 20'd4000;
      upd_q <= 7'd10; tclk_q <= 24'd1000000; move_q <= 16'd24000;
      rs_q <= ST_INIT; ph_q <= PH_STOP; speed_q <= '0; period_q <= 24'd2;
      dir_q <= 1'b0; en_q <= 1'b0; cnt_q <= '0; ms_q <= '0; outv_q <= 1'b0;
      el_q <= '0; num_q <= '0; den_q <= '0; quo_q <= '0; rem_q <= '0;
      est_q <= '0; chg_q <= '0; bit_q <= '0;
    end else begin
      if (wr) begin
        case (paddr)
          REG_START: start_q <= pwdata[SpdW-1:0];
          REG_MAX:   maxs_q <= pwdata[SpdW-1:0];
          REG_ACCEL: acc_q <= pwdata[RateW-1:0];
          REG_DECEL: dec_q <= pwdata[RateW-1:0];
          REG_UPD:   upd_q <= pwdata[MsW-1:0];
          REG_TCLK:  tclk_q <= pwdata[ClkW-1:0];
          REG_MOVE:  move_q <= pwdata[CntW-1:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) outv_q <= 1'b0;
      // iterative divide step, one quotient bit a cycle
      if ((state_q == S_EST_DIV || state_q == S_PER_DIV) && bit_q != '0) begin
        num_q <= {num_q[DW-2:0], 1'b0};
        if (rem_sh >= den_q) begin
          rem_q <= rem_sh - den_q;
          quo_q <= {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[DW-2:0], 1'b0};
        end
        bit_q <= bit_q - 6'd1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            state_q <= S_OUT;
            case (in_if.data.op)
              OP_TICK: begin
                if (running(rs_q)) begin
                  logic [MsW-1:0] m;
                  m = (ms_q < 7'd127) ? ms_q + 7'd1 : ms_q;
                  ms_q <= m;
                  if (m >= upd_q) begin
                    el_q <= (m > 7'd100) ? 7'd100 : m;
                    ms_q <= '0;
                    if (rs_q == ST_DIST && (ph_q == PH_ACCEL || ph_q == PH_CONST))
                      state_q <= S_EST_A;
                    else
                      state_q <= S_CHG_A;
                  end
                end
              end
              OP_STEP: begin
                if (rs_q == ST_DIST) begin
                  if (cnt_q + 16'd1 >= move_q) begin
                    en_q <= 1'b0; cnt_q <= '0; speed_q <= '0; ph_q <= PH_STOP;
                    rs_q <= ST_STOPPED;
                  end else cnt_q <= cnt_q + 16'd1;
                end
              end
              OP_ZERO: begin
                en_q <= 1'b0; cnt_q <= '0; speed_q <= '0; ph_q <= PH_STOP;
                rs_q <= ST_HOME; dir_q <= 1'b1;
              end
              OP_HAND, OP_MOTOR, OP_HOMING, OP_CONT: begin
                logic go;
                logic d;
                logic [StW-1:0] ns;
                go = 1'b0; d = 1'b0; ns = ST_DIST;
                if (in_if.data.op == OP_HAND) begin
                  go = !running(rs_q) && in_if.data.zero_clear;
                end else if (in_if.data.op == OP_MOTOR) begin
                  go = !running(rs_q); d = 1'b1;
                end else if (in_if.data.op == OP_HOMING) begin
                  ns = ST_HOMING;
                  if (!running(rs_q)) begin
                    if (in_if.data.zero_clear) go = 1'b1;
                    else rs_q <= ST_HOME;
                  end
                end else begin
                  ns = ST_CONT; d = in_if.data.dir;
                  if (rs_q == ST_CONT) begin
                    if (dir_q == d) begin
                      if (ph_q == PH_DECEL) begin
                        ph_q <= PH_ACCEL; ms_q <= '0;
                      end
                    end else ph_q <= PH_DECEL;
                  end else if (rs_q != ST_DIST && rs_q != ST_HOMING) begin
                    if (!d && !in_if.data.zero_clear) rs_q <= ST_HOME;
                    else go = 1'b1;
                  end
                end
                if (go) begin
                  speed_q <= start_q; ph_q <= PH_ACCEL; ms_q <= '0; dir_q <= d;
                  cnt_q <= '0; rs_q <= ns; en_q <= 1'b1;
                  if (start_q != '0) begin
                    num_q <= {14'd0, tclk_q}; den_q <= {20'd0, start_q};
                    quo_q <= '0; rem_q <= '0; bit_q <= 6'(DW);
                    state_q <= S_PER_DIV;
                  end
                end
              end
              OP_SOFT: begin
                if (rs_q == ST_CONT && ph_q != PH_DECEL) begin
                  ph_q <= PH_DECEL; ms_q <= '0;
                end
              end
              OP_HARD: begin
                en_q <= 1'b0; cnt_q <= '0; speed_q <= '0; ph_q <= PH_STOP;
                rs_q <= ST_STOPPED; ms_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_EST_A: begin
          est_q <= prod[DW-1:0];
          state_q <= S_EST_B;
        end
        S_EST_B: begin
          if (dec_q == '0 || speed_q <= start_q) begin
            est_q <= '0;
            num_q <= prod[DW-1:0];
            state_q <= S_EST_DIV;
            bit_q <= '0;
          end else begin
            num_q <= est_q - prod[DW-1:0] + {17'd0, dec_q, 1'b0} - 38'd1;
            state_q <= S_EST_DIV;
            bit_q <= 6'(DW);
          end
          den_q <= {17'd0, dec_q, 1'b0};
          quo_q <= '0; rem_q <= '0;
        end
        S_EST_DIV: begin
          if (bit_q == '0) begin
            if (dec_q != '0 && speed_q > start_q) est_q <= quo_q;
            num_q <= prod[DW-1:0];
            state_q <= S_MARG_DIV;
          end
        end
        S_MARG_DIV: begin
          quo_q <= ms_quo;
          state_q <= S_CHK;
        end
        S_CHK: begin
          logic [DW-1:0] remain;
          remain = (cnt_q >= move_q) ? '0 : DW'(move_q - cnt_q);
          if (remain <= est_q + quo_q + 38'd1) ph_q <= PH_DECEL;
          state_q <= S_CHG_A;
        end
        S_CHG_A: begin
          num_q <= prod[DW-1:0];
          if (ph_q == PH_CONST) state_q <= S_OUT;
          else if (ph_q == PH_STOP) begin
            en_q <= 1'b0; speed_q <= '0; rs_q <= ST_STOPPED; state_q <= S_OUT;
          end else if (ph_q == PH_DECEL && rs_q != ST_DIST && rs_q != ST_CONT) begin
            ph_q <= PH_ACCEL; state_q <= S_OUT;
          end else state_q <= S_CHG_DIV;
        end
        S_CHG_DIV: begin
          chg_q <= (ms_quo == '0) ? 38'd1 : ms_quo;
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          logic [SpdW-1:0] ns;
          logic ld;
          ns = speed_q; ld = 1'b1;
          if (ph_q == PH_ACCEL) begin
            if (speed_q >= maxs_q || chg_q >= DW'(maxs_q - speed_q)) begin
              ns = maxs_q; ph_q <= PH_CONST;
            end else ns = speed_q + SpdW'(chg_q);
          end else if (DW'(speed_q) <= DW'(start_q) + chg_q) begin
            if (rs_q == ST_DIST) ns = start_q;
            else begin
              ld = 1'b0; ns = '0; en_q <= 1'b0; cnt_q <= '0; ph_q <= PH_STOP;
              rs_q <= ST_STOPPED;
            end
          end else ns = speed_q - SpdW'(chg_q);
          speed_q <= ns;
          num_q <= {14'd0, tclk_q}; den_q <= {20'd0, ns};
          quo_q <= '0; rem_q <= '0; bit_q <= 6'(DW);
          state_q <= (ld && ns != '0) ? S_PER_DIV : S_OUT;
        end
        S_PER_DIV: begin
          if (bit_q == '0) begin
            period_q <= (quo_q < 38'd2) ? 24'd2 : quo_q[ClkW-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          outv_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/tsr_checker.sv
`default_nettype none
module tsr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] ramp_phase,
  input wire logic [17:0] speed,
  input wire logic [23:0] step_period,
  input wire logic drive_enable
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(speed)) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("accepted while result pending");
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && ramp_phase == 2'd0 |-> speed == 18'd0 && !drive_enable)
    else $error("stopped but moving");
  a_per: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> step_period >= 24'd2) else $error("period too short");
endmodule

bind trapezoid_stepper_ramp_top tsr_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .ramp_phase(out_if.data.ramp_phase),
  .speed(out_if.data.speed), .step_period(out_if.data.step_period),
  .drive_enable(out_if.data.drive_enable)
);
`default_nettype wire
